/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SME_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define SME_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define SME_ASSERT(lbl, clk, rst, prop)
`define SME_NEVER(lbl, clk, rst, expr)
`endif

`endif

/* hw/rtl/sme_pkg.sv */
`default_nettype none
package sme_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int RAM_DEPTH   = 2 * MAX_SAMPLES;
  localparam int RAM_AW      = ADDR_W + 1;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 16;
  localparam int SUM_W    = SAMPLE_W + ADDR_W;

  // result field widths
  localparam int COUNT_W = 11;
  localparam int MEAN_W  = 32;
  localparam int VAR_W   = 47;
  localparam int DEV_W   = 32;
  localparam int SKEW_W  = 23;
  localparam int KURT_W  = 28;
  localparam int STAT_W  = 2;

  localparam int OUT_W       = COUNT_W + MEAN_W + VAR_W + DEV_W + SKEW_W + KURT_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int PAD_W       = OUT_TDATA_W - OUT_W;

  // datapath widths
  localparam int D_W      = MEAN_W + 2;
  localparam int MAG_W    = 32;
  localparam int SQ_W     = 2 * MAG_W - FRAC_W;
  localparam int SQSUM_W  = SQ_W + ADDR_W;
  localparam int Z_W      = 25;
  localparam int S_W      = 33;
  localparam int C_W      = 41;
  localparam int F_W      = 49;
  localparam int CUBE_W   = C_W + ADDR_W + 1;
  localparam int QUAD_W   = F_W + ADDR_W;
  localparam int MUL_W    = 33;
  localparam int PROD_W   = 2 * MUL_W;

  localparam int DIV_NW    = 64;
  localparam int DIV_DW    = 32;
  localparam int DIV_CNT_W = $clog2(DIV_NW + 1);

  localparam int SQRT_STEPS = DIV_NW / 2;
  localparam int SQRT_CW    = $clog2(SQRT_STEPS);

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_FW    = $clog2(Q_DEPTH + 1);

  localparam int Z_CAP       = 16777216;
  localparam int SKEW_MAX    = 2097152;
  localparam int KURT_OFFSET = 3 * (1 << FRAC_W);
  localparam int KURT_MAX    = 67108864;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO_DEV = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DROPPED  = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [SUM_W-1:0] sum;
    logic                    dropped;
    logic                    bank;
  } job_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  // count sits in the low bits
  typedef struct packed {
    logic [KURT_W-1:0]  kurtosis;
    logic [SKEW_W-1:0]  skewness;
    logic [DEV_W-1:0]   deviation;
    logic [VAR_W-1:0]   variance;
    logic [MEAN_W-1:0]  mean;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage
`default_nettype wire

/* hw/rtl/sme_ram.sv */
`default_nettype none
module sme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/sme_div.sv */
`default_nettype none
module sme_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sme_pkg::div_req_t  req,
  output sme_pkg::div_rsp_t       rsp
);

  logic                              busy;
  logic                              done;
  logic [sme_pkg::DIV_CNT_W-1:0]     cnt;
  logic [sme_pkg::DIV_DW-1:0]        rem;
  logic [sme_pkg::DIV_NW-1:0]        quot;
  logic [sme_pkg::DIV_DW-1:0]        dsr;
  logic [sme_pkg::DIV_DW:0]          trial;
  logic [sme_pkg::DIV_DW:0]          diff;
  logic                              ge;
  logic [sme_pkg::DIV_DW-1:0]        rem_next;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial    = {rem, quot[sme_pkg::DIV_NW-1]};
    diff     = trial - {1'b0, dsr};
    ge       = trial >= {1'b0, dsr};
    rem_next = ge ? diff[sme_pkg::DIV_DW-1:0] : trial[sme_pkg::DIV_DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= sme_pkg::DIV_CNT_W'(sme_pkg::DIV_NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == sme_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quot <= req.dividend;
      dsr  <= req.divisor;
    end else if (busy) begin
      rem  <= rem_next;
      quot <= {quot[sme_pkg::DIV_NW-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quot;

endmodule
`default_nettype wire

/* hw/rtl/sme_fifo.sv */
`default_nettype none
`include "assert_macros.svh"
module sme_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire sme_pkg::job_t  wr_job,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output sme_pkg::job_t       rd_job
);

  sme_pkg::job_t                mem [sme_pkg::Q_DEPTH];
  logic [sme_pkg::Q_AW-1:0]     wr_ptr;
  logic [sme_pkg::Q_AW-1:0]     rd_ptr;
  logic [sme_pkg::Q_FW-1:0]     fill;

  assign full   = fill == sme_pkg::Q_FW'(sme_pkg::Q_DEPTH);
  assign valid  = fill != '0;
  assign rd_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  `SME_NEVER(a_q_no_overrun, clk, rst, push && full)
  `SME_NEVER(a_q_no_underrun, clk, rst, pop && !valid)

endmodule
`default_nettype wire

/* hw/rtl/sme_front.sv */
`default_nettype none
module sme_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_valid,
  output logic                                 s_ready,
  input  wire logic signed [sme_pkg::SAMPLE_W-1:0] s_sample,
  input  wire logic                            s_last,
  output logic                                 ram_we,
  output logic [sme_pkg::RAM_AW-1:0]           ram_waddr,
  output logic [sme_pkg::SAMPLE_W-1:0]         ram_wdata,
  output logic                                 push,
  output sme_pkg::job_t                        job,
  input  wire logic                            q_full,
  input  wire sme_pkg::bank_rel_t              rel
);

  logic [sme_pkg::CNT_W-1:0]        count;
  logic signed [sme_pkg::SUM_W-1:0] sum;
  logic                             dropped;
  logic                             wbank;
  logic [1:0]                       busy;
  logic [1:0]                       busy_next;
  logic                             accept;
  logic                             buf_full;
  logic                             store;

  assign s_ready  = !busy[wbank] && !q_full;
  assign accept   = s_valid && s_ready;
  assign buf_full = count == sme_pkg::CNT_W'(sme_pkg::MAX_SAMPLES);
  assign store    = accept && !buf_full;
  assign push     = accept && s_last;

  assign ram_we    = store;
  assign ram_waddr = {wbank, count[sme_pkg::ADDR_W-1:0]};
  assign ram_wdata = s_sample;

  always_comb begin
    job.count   = count + sme_pkg::CNT_W'(store);
    job.sum     = store ? sum + sme_pkg::SUM_W'(s_sample) : sum;
    job.dropped = dropped || (accept && buf_full);
    job.bank    = wbank;
    busy_next   = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (push) begin
      busy_next[wbank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      sum     <= '0;
      dropped <= 1'b0;
      wbank   <= 1'b0;
      busy    <= '0;
    end else begin
      busy <= busy_next;
      if (push) begin
        count   <= '0;
        sum     <= '0;
        dropped <= 1'b0;
        wbank   <= ~wbank;
      end else if (accept) begin
        count   <= job.count;
        sum     <= job.sum;
        dropped <= job.dropped;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/sme_back.sv */
`default_nettype none
`include "assert_macros.svh"
module sme_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        job_valid,
  input  wire sme_pkg::job_t               job,
  output logic                             job_pop,
  output logic [sme_pkg::RAM_AW-1:0]       ram_raddr,
  input  wire logic [sme_pkg::SAMPLE_W-1:0] ram_rdata,
  output sme_pkg::div_req_t                div_req,
  input  wire sme_pkg::div_rsp_t           div_rsp,
  output sme_pkg::bank_rel_t               rel,
  output logic                             m_valid,
  input  wire logic                        m_ready,
  output sme_pkg::result_t                 res,
  output logic [sme_pkg::STAT_W-1:0]       status
);

  typedef enum logic [17:0] {
    ST_IDLE    = 18'h00001,
    ST_MEAN    = 18'h00002,
    ST_P1_ADDR = 18'h00004,
    ST_P1_DIFF = 18'h00008,
    ST_P1_SQ   = 18'h00010,
    ST_P1_ACC  = 18'h00020,
    ST_VAR     = 18'h00040,
    ST_SQRT    = 18'h00080,
    ST_P2_ADDR = 18'h00100,
    ST_P2_DIFF = 18'h00200,
    ST_P2_DIV  = 18'h00400,
    ST_P2_ZZ   = 18'h00800,
    ST_P2_SZ   = 18'h01000,
    ST_P2_SS   = 18'h02000,
    ST_P2_ACC  = 18'h04000,
    ST_SKEW    = 18'h08000,
    ST_KURT    = 18'h10000,
    ST_OUT     = 18'h20000
  } state_t;

  localparam logic [sme_pkg::DIV_NW-1:0] SQRT_TOP = sme_pkg::DIV_NW'(1) << (sme_pkg::DIV_NW - 2);

  state_t state;

  logic [sme_pkg::CNT_W-1:0]          n;
  logic [sme_pkg::CNT_W-1:0]          n_m1;
  logic                               dropped;
  logic                               bank;
  logic                               sum_neg;
  logic [sme_pkg::ADDR_W-1:0]         idx;
  logic                               last_w;
  logic signed [sme_pkg::MEAN_W-1:0]  mean;
  logic                               d_neg;
  logic [sme_pkg::MAG_W-1:0]          mag;
  logic [sme_pkg::SQSUM_W-1:0]        sq_sum;
  logic [sme_pkg::SQSUM_W-1:0]        sq_next;
  logic [sme_pkg::VAR_W-1:0]          var_q;
  logic [sme_pkg::DIV_NW-1:0]         sv;
  logic [sme_pkg::DIV_NW-1:0]         sr;
  logic [sme_pkg::DIV_NW-1:0]         sbit;
  logic [sme_pkg::DIV_NW-1:0]         st;
  logic                               sge;
  logic [sme_pkg::DIV_NW-1:0]         sv_next;
  logic [sme_pkg::DIV_NW-1:0]         sr_next;
  logic [sme_pkg::SQRT_CW-1:0]        step;
  logic [sme_pkg::DEV_W-1:0]          dev;
  logic [sme_pkg::Z_W-1:0]            z;
  logic [sme_pkg::S_W-1:0]            s;
  logic [sme_pkg::S_W-1:0]            s_w;
  logic [sme_pkg::C_W-1:0]            c;
  logic signed [sme_pkg::CUBE_W-1:0]  cube_sum;
  logic signed [sme_pkg::CUBE_W-1:0]  c_ext;
  logic signed [sme_pkg::CUBE_W-1:0]  cube_next;
  logic [sme_pkg::CUBE_W-1:0]         cube_abs;
  logic [sme_pkg::QUAD_W-1:0]         quad_sum;
  logic [sme_pkg::QUAD_W-1:0]         quad_next;
  logic [sme_pkg::PROD_W-1:0]         prod;
  logic [sme_pkg::MUL_W-1:0]          mul_a;
  logic [sme_pkg::MUL_W-1:0]          mul_b;
  logic signed [sme_pkg::D_W-1:0]     xs_w;
  logic signed [sme_pkg::D_W-1:0]     diff_w;
  logic [sme_pkg::D_W-1:0]            absd_w;
  logic [sme_pkg::SUM_W-1:0]          abs_sum;
  logic [sme_pkg::DIV_NW-1:0]         q;
  logic [sme_pkg::SKEW_W-1:0]         skew_mag;
  logic signed [sme_pkg::SKEW_W-1:0]  skew;
  logic signed [sme_pkg::KURT_W-1:0]  kurt;
  logic                               div_start;
  logic [sme_pkg::DIV_NW-1:0]         div_dividend;
  logic [sme_pkg::DIV_DW-1:0]         div_divisor;
  logic                               rel_valid;
  logic                               rel_bank;

  assign q       = div_rsp.quotient;
  assign job_pop = (state == ST_IDLE) && job_valid;
  assign n_m1    = n - sme_pkg::CNT_W'(1);
  assign last_w  = idx == n_m1[sme_pkg::ADDR_W-1:0];
  assign ram_raddr = {bank, idx};

  assign div_req.start    = div_start;
  assign div_req.dividend = div_dividend;
  assign div_req.divisor  = div_divisor;
  assign rel.valid        = rel_valid;
  assign rel.bank         = rel_bank;

  always_comb begin
    abs_sum = job.sum[sme_pkg::SUM_W-1] ? sme_pkg::SUM_W'(-job.sum) : sme_pkg::SUM_W'(job.sum);
    // deviation of one sample from the mean, 16 fraction bits
    xs_w   = sme_pkg::D_W'($signed({ram_rdata, {sme_pkg::FRAC_W{1'b0}}}));
    diff_w = xs_w - sme_pkg::D_W'(mean);
    absd_w = diff_w[sme_pkg::D_W-1] ? sme_pkg::D_W'(-diff_w) : sme_pkg::D_W'(diff_w);
    sq_next = sq_sum + sme_pkg::SQSUM_W'(prod[sme_pkg::FRAC_W +: sme_pkg::SQ_W]);
    // digit-by-digit square root step
    st      = sr + sbit;
    sge     = sv >= st;
    sv_next = sge ? sv - st : sv;
    sr_next = sge ? (sr >> 1) + sbit : sr >> 1;
    s_w       = prod[sme_pkg::FRAC_W +: sme_pkg::S_W];
    c_ext     = sme_pkg::CUBE_W'(c);
    cube_next = d_neg ? cube_sum - c_ext : cube_sum + c_ext;
    cube_abs  = cube_next[sme_pkg::CUBE_W-1] ? sme_pkg::CUBE_W'(-cube_next)
                                             : sme_pkg::CUBE_W'(cube_next);
    quad_next = quad_sum + sme_pkg::QUAD_W'(prod[sme_pkg::FRAC_W +: sme_pkg::F_W]);
    skew_mag  = (q > sme_pkg::DIV_NW'(sme_pkg::SKEW_MAX)) ? sme_pkg::SKEW_W'(sme_pkg::SKEW_MAX)
                                                          : q[sme_pkg::SKEW_W-1:0];
  end

  // one shared multiplier, product registered
  always_comb begin
    mul_a = sme_pkg::MUL_W'(mag);
    mul_b = sme_pkg::MUL_W'(mag);
    case (state)
      ST_P2_ZZ: begin
        mul_a = sme_pkg::MUL_W'(z);
        mul_b = sme_pkg::MUL_W'(z);
      end
      ST_P2_SZ: begin
        mul_a = sme_pkg::MUL_W'(s_w);
        mul_b = sme_pkg::MUL_W'(z);
      end
      ST_P2_SS: begin
        mul_a = sme_pkg::MUL_W'(s);
        mul_b = sme_pkg::MUL_W'(s);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      m_valid   <= 1'b0;
      div_start <= 1'b0;
      rel_valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      rel_valid <= 1'b0;
      if (m_valid && m_ready) begin
        m_valid <= 1'b0;
      end
      prod <= sme_pkg::PROD_W'(mul_a) * sme_pkg::PROD_W'(mul_b);
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            n            <= job.count;
            dropped      <= job.dropped;
            bank         <= job.bank;
            sum_neg      <= job.sum[sme_pkg::SUM_W-1];
            div_start    <= 1'b1;
            div_dividend <= sme_pkg::DIV_NW'({abs_sum, {sme_pkg::FRAC_W{1'b0}}});
            div_divisor  <= sme_pkg::DIV_DW'(job.count);
            state        <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          if (div_rsp.done) begin
            mean   <= sum_neg ? -sme_pkg::MEAN_W'(q) : sme_pkg::MEAN_W'(q);
            idx    <= '0;
            sq_sum <= '0;
            state  <= ST_P1_ADDR;
          end
        end
        ST_P1_ADDR: state <= ST_P1_DIFF;
        ST_P1_DIFF: begin
          mag   <= absd_w[sme_pkg::MAG_W-1:0];
          d_neg <= diff_w[sme_pkg::D_W-1];
          state <= ST_P1_SQ;
        end
        ST_P1_SQ: state <= ST_P1_ACC;
        ST_P1_ACC: begin
          sq_sum <= sq_next;
          if (last_w) begin
            div_start    <= 1'b1;
            div_dividend <= sme_pkg::DIV_NW'(sq_next);
            div_divisor  <= sme_pkg::DIV_DW'(n);
            state        <= ST_VAR;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_P1_ADDR;
          end
        end
        ST_VAR: begin
          if (div_rsp.done) begin
            var_q <= q[sme_pkg::VAR_W-1:0];
            sv    <= sme_pkg::DIV_NW'({q[sme_pkg::VAR_W-1:0], {sme_pkg::FRAC_W{1'b0}}});
            sr    <= '0;
            sbit  <= SQRT_TOP;
            step  <= '0;
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          sv   <= sv_next;
          sr   <= sr_next;
          sbit <= sbit >> 2;
          step <= step + 1'b1;
          if (step == sme_pkg::SQRT_CW'(sme_pkg::SQRT_STEPS - 1)) begin
            dev <= sr_next[sme_pkg::DEV_W-1:0];
            if (sr_next[sme_pkg::DEV_W-1:0] == '0) begin
              skew  <= '0;
              kurt  <= '0;
              state <= ST_OUT;
            end else begin
              idx      <= '0;
              cube_sum <= '0;
              quad_sum <= '0;
              state    <= ST_P2_ADDR;
            end
          end
        end
        ST_P2_ADDR: state <= ST_P2_DIFF;
        ST_P2_DIFF: begin
          mag          <= absd_w[sme_pkg::MAG_W-1:0];
          d_neg        <= diff_w[sme_pkg::D_W-1];
          div_start    <= 1'b1;
          div_dividend <= sme_pkg::DIV_NW'({absd_w[sme_pkg::MAG_W-1:0],
                                            {sme_pkg::FRAC_W{1'b0}}});
          div_divisor  <= dev;
          state        <= ST_P2_DIV;
        end
        ST_P2_DIV: begin
          if (div_rsp.done) begin
            z <= (q > sme_pkg::DIV_NW'(sme_pkg::Z_CAP)) ? sme_pkg::Z_W'(sme_pkg::Z_CAP)
                                                        : q[sme_pkg::Z_W-1:0];
            state <= ST_P2_ZZ;
          end
        end
        ST_P2_ZZ: state <= ST_P2_SZ;
        ST_P2_SZ: begin
          s     <= s_w;
          state <= ST_P2_SS;
        end
        ST_P2_SS: begin
          c     <= prod[sme_pkg::FRAC_W +: sme_pkg::C_W];
          state <= ST_P2_ACC;
        end
        ST_P2_ACC: begin
          cube_sum <= cube_next;
          quad_sum <= quad_next;
          if (last_w) begin
            div_start    <= 1'b1;
            div_dividend <= sme_pkg::DIV_NW'(cube_abs);
            div_divisor  <= sme_pkg::DIV_DW'(n);
            state        <= ST_SKEW;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_P2_ADDR;
          end
        end
        ST_SKEW: begin
          if (div_rsp.done) begin
            skew <= cube_sum[sme_pkg::CUBE_W-1] ? -skew_mag : skew_mag;
            div_start    <= 1'b1;
            div_dividend <= sme_pkg::DIV_NW'(quad_sum);
            div_divisor  <= sme_pkg::DIV_DW'(n);
            state        <= ST_KURT;
          end
        end
        ST_KURT: begin
          if (div_rsp.done) begin
            if (q > sme_pkg::DIV_NW'(sme_pkg::KURT_MAX + sme_pkg::KURT_OFFSET)) begin
              kurt <= sme_pkg::KURT_W'(sme_pkg::KURT_MAX);
            end else begin
              kurt <= sme_pkg::KURT_W'(q - sme_pkg::DIV_NW'(sme_pkg::KURT_OFFSET));
            end
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_valid || m_ready) begin
            res.count     <= sme_pkg::COUNT_W'(n);
            res.mean      <= mean;
            res.variance  <= var_q;
            res.deviation <= dev;
            res.skewness  <= skew;
            res.kurtosis  <= kurt;
            if (dropped) begin
              status <= sme_pkg::STAT_DROPPED;
            end else if (dev == '0) begin
              status <= sme_pkg::STAT_ZERO_DEV;
            end else begin
              status <= sme_pkg::STAT_OK;
            end
            m_valid   <= 1'b1;
            rel_valid <= 1'b1;
            rel_bank  <= bank;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SME_ASSERT(a_div_done_waited, clk, rst, div_rsp.done |-> (state == ST_MEAN || state == ST_VAR || state == ST_P2_DIV || state == ST_SKEW || state == ST_KURT))
  `SME_ASSERT(a_skew_bounded, clk, rst, m_valid |-> ($signed(res.skewness) <= sme_pkg::SKEW_MAX && $signed(res.skewness) >= -sme_pkg::SKEW_MAX))
  `SME_ASSERT(a_zero_dev_clean, clk, rst, (m_valid && res.deviation == '0) |-> (res.skewness == '0 && res.kurtosis == '0 && status != sme_pkg::STAT_OK))

endmodule
`default_nettype wire

/* hw/rtl/sample_moments_engine_core.sv */
// Input: one sample per cycle into a free buffer bank while the job queue is not full;
//   two banks let one set load while the previous set is worked on.
// Timing: the first pass reads each stored sample once; when the deviation is nonzero,
//   a second pass follows, using the 64-step serial divider once per sample.
// Reset: synchronous rst clears counters, bank flags, queue and handshakes;
//   sample memory is not cleared, only entries written in the current set are read.
`default_nettype none
module sample_moments_engine_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [15:0]                        s_axis_tdata,  // [15:0] sample
  input  wire logic                               s_axis_tlast,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [10:0] sample_count, [42:11] mean_value, [89:43] variance_value,
  // [121:90] deviation_value, [144:122] skewness_value, [172:145] kurtosis_value
  output logic [sme_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  output logic [sme_pkg::STAT_W-1:0]              m_axis_tuser   // [1:0] status_code
);

  logic                               ram_we;
  logic [sme_pkg::RAM_AW-1:0]         ram_waddr;
  logic [sme_pkg::SAMPLE_W-1:0]       ram_wdata;
  logic [sme_pkg::RAM_AW-1:0]         ram_raddr;
  logic [sme_pkg::SAMPLE_W-1:0]       ram_rdata;
  logic                               q_push;
  logic                               q_full;
  logic                               q_pop;
  logic                               q_valid;
  sme_pkg::job_t                      wr_job;
  sme_pkg::job_t                      rd_job;
  sme_pkg::bank_rel_t                 rel;
  sme_pkg::div_req_t                  div_req;
  sme_pkg::div_rsp_t                  div_rsp;
  sme_pkg::result_t                   res;

  sme_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_axis_tvalid),
    .s_ready   (s_axis_tready),
    .s_sample  ($signed(s_axis_tdata)),
    .s_last    (s_axis_tlast),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .push      (q_push),
    .job       (wr_job),
    .q_full    (q_full),
    .rel       (rel)
  );

  sme_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (wr_job),
    .full   (q_full),
    .pop    (q_pop),
    .valid  (q_valid),
    .rd_job (rd_job)
  );

  sme_ram #(
    .WIDTH (sme_pkg::SAMPLE_W),
    .DEPTH (sme_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sme_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  sme_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job       (rd_job),
    .job_pop   (q_pop),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .rel       (rel),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .res       (res),
    .status    (m_axis_tuser)
  );

  assign m_axis_tdata = {{sme_pkg::PAD_W{1'b0}}, res};

endmodule
`default_nettype wire
